// ===== rtl/core/lchp_pkg.sv =====
// Shared types and constants for the load cell hit/press detector.
`default_nettype none

package lchp_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int PULSE_W     = 5;
    localparam int PIN_W       = 4;
    localparam int OUT_CH      = 4;
    localparam int OUT_W       = 17;
    localparam int THR_W       = 17;
    localparam int MAX_CH      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;

    localparam logic [SAMPLE_BITS-1:0] SIGN_FLIP = 24'h800000;

    localparam logic [CFG_IDX_W-1:0] CFG_HIT_THR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_THR = 2'd1;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [THR_W-1:0] hit_thr;
        logic [THR_W-1:0] press_thr;
    } thr_cfg_t;

    typedef struct packed {
        logic [PIN_W-1:0]             sck;
        logic                         done;
        logic [OUT_CH-1:0][OUT_W-1:0] weight;
        logic [PIN_W-1:0]             hit;
        logic [PIN_W-1:0]             press;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/lchp_if.sv =====
// Valid/ready channel interfaces for pin samples and status results.
`default_nettype none

interface lchp_in_if
    import lchp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIN_W-1:0] dout_lines;

    modport source (output valid, output dout_lines, input ready);
    modport sink   (input valid, input dout_lines, output ready);
endinterface

interface lchp_out_if
    import lchp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIN_W-1:0] sck_lines;
    logic             round_done;
    logic [OUT_W-1:0] weight_ch0;
    logic [OUT_W-1:0] weight_ch1;
    logic [OUT_W-1:0] weight_ch2;
    logic [OUT_W-1:0] weight_ch3;
    logic [PIN_W-1:0] hit_flags;
    logic [PIN_W-1:0] press_flags;

    modport source (output valid, output sck_lines, output round_done,
                    output weight_ch0, output weight_ch1, output weight_ch2,
                    output weight_ch3, output hit_flags, output press_flags,
                    input ready);
    modport sink   (input valid, input sck_lines, input round_done,
                    input weight_ch0, input weight_ch1, input weight_ch2,
                    input weight_ch3, input hit_flags, input press_flags,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lchp_queue.sv =====
// Front end: accepts pin samples into a two-entry queue.
`default_nettype none

module lchp_queue
    import lchp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [PIN_W-1:0] in_data,
    output logic                  head_valid,
    output logic [PIN_W-1:0]      head_data,
    input  wire logic             deq
);

    logic [PIN_W-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    logic             pop;

    assign in_ready   = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = deq && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lchp_engine.sv =====
// Back end: serial clock sequencer, word capture, hit/press detection.
`default_nettype none

module lchp_engine
    import lchp_pkg::*;
#(
    parameter int CHANNELS  = 4,
    parameter int KEPT_BITS = 17
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire thr_cfg_t         cfg,
    input  wire logic             head_valid,
    input  wire logic [PIN_W-1:0] head_data,
    output logic                  deq,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output result_t               result
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMP_W = ((KEPT_BITS > THR_W) ? KEPT_BITS : THR_W) + 1;

    phase_t                 phase_reg, phase_next;
    logic [PULSE_W-1:0]     pulse_reg, pulse_next;
    logic [CH_W-1:0]        chan_reg, chan_next;
    logic [SAMPLE_BITS-1:0] shift_reg, shift_next;
    logic [KEPT_BITS-1:0]   readings_reg [CHANNELS];
    logic [KEPT_BITS-1:0]   readings_next [CHANNELS];
    logic [KEPT_BITS-1:0]   prev_reg [CHANNELS];
    logic [KEPT_BITS-1:0]   prev_next [CHANNELS];
    logic [KEPT_BITS-1:0]   base_reg [CHANNELS];
    logic [KEPT_BITS-1:0]   base_next [CHANNELS];
    logic [CHANNELS-1:0]    hit_reg, hit_next;
    logic [CHANNELS-1:0]    press_reg, press_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                result_reg;

    logic                   step;
    logic [2:0]             ch3;
    logic                   dout_bit;
    logic [PIN_W-1:0]       sck_sel;
    logic [PIN_W-1:0]       sck;
    logic                   done;
    logic [PULSE_W-1:0]     pulse_inc;
    logic                   last_pulse;
    logic [SAMPLE_BITS-1:0] word;
    logic [KEPT_BITS-1:0]   value;
    logic                   hit_cond;
    logic                   press_cond;
    logic [OUT_CH-1:0][OUT_W-1:0] weight_w;
    logic [MAX_CH-1:0]      hit_pad;
    logic [MAX_CH-1:0]      press_pad;

    assign step      = head_valid && (!out_valid_reg || out_ready);
    assign deq       = step;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // channels past the pin width see data-out low and get no clock
    assign ch3        = 3'(chan_reg);
    assign dout_bit   = (ch3 < 3'(PIN_W)) ? head_data[ch3[1:0]] : 1'b0;
    assign sck_sel    = (ch3 < 3'(PIN_W)) ? (PIN_W'(1) << ch3[1:0]) : '0;
    assign pulse_inc  = pulse_reg + PULSE_W'(1);
    assign last_pulse = (pulse_inc >= PULSE_W'(SAMPLE_BITS + 1));

    assign word       = shift_reg ^ SIGN_FLIP;
    assign value      = word[SAMPLE_BITS-1 -: KEPT_BITS];
    assign hit_cond   = (CMP_W'(prev_reg[chan_reg]) + CMP_W'(cfg.hit_thr)) < CMP_W'(value);
    assign press_cond = (CMP_W'(value) + CMP_W'(cfg.press_thr)) < CMP_W'(base_reg[chan_reg]);

    // next phase
    always_comb
    begin
        unique case (phase_reg)
            PH_HIGH: phase_next = PH_LOW;
            PH_LOW:  phase_next = last_pulse ? PH_WAIT : PH_HIGH;
            default: phase_next = dout_bit ? PH_WAIT : PH_HIGH;
        endcase
    end

    // per-phase outputs and datapath updates
    always_comb
    begin
        sck           = '0;
        done          = 1'b0;
        pulse_next    = pulse_reg;
        chan_next     = chan_reg;
        shift_next    = shift_reg;
        readings_next = readings_reg;
        prev_next     = prev_reg;
        base_next     = base_reg;
        hit_next      = hit_reg;
        press_next    = press_reg;
        unique case (phase_reg)
            PH_HIGH:
            begin
                sck = sck_sel;
            end
            PH_LOW:
            begin
                if (pulse_reg < PULSE_W'(SAMPLE_BITS))
                begin
                    shift_next = {shift_reg[SAMPLE_BITS-2:0], dout_bit};
                end
                pulse_next = pulse_inc;
                if (last_pulse)
                begin
                    readings_next[chan_reg] = value;
                    prev_next[chan_reg]     = value;
                    hit_next[chan_reg]      = hit_cond;
                    press_next[chan_reg]    = press_cond;
                    pulse_next              = '0;
                    shift_next              = '0;
                    if (chan_reg == CH_W'(CHANNELS - 1))
                    begin
                        done      = 1'b1;
                        chan_next = '0;
                        if (&hit_next)
                        begin
                            base_next = readings_next;
                        end
                    end
                    else
                    begin
                        chan_next = chan_reg + CH_W'(1);
                    end
                end
            end
            default:
            begin
                if (!dout_bit)
                begin
                    pulse_next = '0;
                    shift_next = '0;
                end
            end
        endcase
    end

    for (genvar k = 0; k < OUT_CH; k++)
    begin : g_weight
        if (k < CHANNELS)
        begin : g_live
            assign weight_w[k] = OUT_W'(readings_next[k]);
        end
        else
        begin : g_idle
            assign weight_w[k] = '0;
        end
    end

    assign hit_pad   = MAX_CH'(hit_next);
    assign press_pad = MAX_CH'(press_next);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            pulse_reg     <= '0;
            chan_reg      <= '0;
            shift_reg     <= '0;
            hit_reg       <= '0;
            press_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                readings_reg[i] <= '0;
                prev_reg[i]     <= '0;
                base_reg[i]     <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                phase_reg    <= phase_next;
                pulse_reg    <= pulse_next;
                chan_reg     <= chan_next;
                shift_reg    <= shift_next;
                hit_reg      <= hit_next;
                press_reg    <= press_next;
                readings_reg <= readings_next;
                prev_reg     <= prev_next;
                base_reg     <= base_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg.sck    <= sck;
            result_reg.done   <= done;
            result_reg.weight <= weight_w;
            result_reg.hit    <= hit_pad[PIN_W-1:0];
            result_reg.press  <= press_pad[PIN_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/load_cell_hit_press_detector_core.sv =====
// A sample is written into the input queue and its status is registered in the
// output register. Throughput: one sample, one sequencer tick, per cycle unless
// the status output stalls. The two-entry queue takes samples while a status
// waits, until full. Reset (async, active low) clears the queue, the valid flag,
// the sequencer (waiting for ready on channel 0), readings, baseline and flags.
`default_nettype none

module load_cell_hit_press_detector_core
    import lchp_pkg::*;
#(
    parameter int CHANNELS  = 4,
    parameter int KEPT_BITS = 17
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    lchp_in_if.sink                    pins,
    lchp_out_if.source                 status,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    thr_cfg_t         cfg_reg;
    logic             head_valid;
    logic [PIN_W-1:0] head_data;
    logic             deq;
    result_t          result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_HIT_THR)
            begin
                cfg_reg.hit_thr <= cfg_data[THR_W-1:0];
            end
            else if (cfg_index == CFG_PRESS_THR)
            begin
                cfg_reg.press_thr <= cfg_data[THR_W-1:0];
            end
        end
    end

    lchp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (pins.valid),
        .in_ready   (pins.ready),
        .in_data    (pins.dout_lines),
        .head_valid (head_valid),
        .head_data  (head_data),
        .deq        (deq)
    );

    lchp_engine #(
        .CHANNELS  (CHANNELS),
        .KEPT_BITS (KEPT_BITS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_data  (head_data),
        .deq        (deq),
        .out_valid  (status.valid),
        .out_ready  (status.ready),
        .result     (result)
    );

    assign status.sck_lines   = result.sck;
    assign status.round_done  = result.done;
    assign status.weight_ch0  = result.weight[0];
    assign status.weight_ch1  = result.weight[1];
    assign status.weight_ch2  = result.weight[2];
    assign status.weight_ch3  = result.weight[3];
    assign status.hit_flags   = result.hit;
    assign status.press_flags = result.press;

endmodule

`default_nettype wire
